@@ hw/rtl/sact_pkg.sv @@
package sact_pkg;

    // Default sizes of the tag store.
    localparam int NUM_SETS_DEF  = 64;
    localparam int NUM_WAYS_DEF  = 8;
    localparam int ADDR_BITS_DEF = 32;

    // Fixed field widths.
    localparam int TAG_W      = 32;
    localparam int WAY_OUT_W  = 3;
    localparam int POLICY_W   = 2;
    localparam int WAYS_LOG_W = 2;
    localparam int SETS_LOG_W = 3;
    localparam int OFFSET_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int OFFSET_MAX = 12;
    localparam int LFSR_W     = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETS_LOG2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd3;

    // Replacement policy codes; the unused code behaves as true LRU.
    localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LRU    = 2'd1;
    localparam logic [POLICY_W-1:0] POL_PLRU   = 2'd2;

    // Reset values.
    localparam logic [POLICY_W-1:0]   POLICY_RST    = POL_LRU;
    localparam logic [WAYS_LOG_W-1:0] WAYS_LOG_RST  = 2'd2;
    localparam logic [SETS_LOG_W-1:0] SETS_LOG_RST  = 3'd6;
    localparam logic [OFFSET_W-1:0]   OFFSET_RST    = 4'd6;
    localparam logic [LFSR_W-1:0]     LFSR_SEED     = 16'hACE1;
    localparam logic [LFSR_W-1:0]     LFSR_TAPS     = 16'hB400;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } back_state_t;

endpackage

@@ hw/rtl/sact_ram.sv @@
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; read data holds without a read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/sact_front.sv @@
module sact_front #(
    parameter int NUM_SETS  = sact_pkg::NUM_SETS_DEF,
    parameter int ADDR_BITS = sact_pkg::ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sact_pkg::SETS_LOG_W-1:0]   sets_eff,
    input  logic [sact_pkg::OFFSET_W-1:0]     offset_eff,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ADDR_BITS-1:0]              address,
    input  logic                              operation,
    output logic                              q_valid,
    input  logic                              q_ready,
    output logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] q_set,
    output logic [sact_pkg::TAG_W-1:0]        q_tag,
    output logic                              q_wr
);
    import sact_pkg::*;

    localparam int SET_W = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;

    logic [ADDR_BITS-1:0] addr_off;
    logic [ADDR_BITS-1:0] addr_tag;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     set_idx;
    logic [TAG_W-1:0]     tag_val;

    logic [SET_W-1:0] set_q_reg [2];
    logic [TAG_W-1:0] tag_q_reg [2];
    logic             wr_q_reg  [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    // Split the address into set index and tag with the current layout.
    always_comb
    begin
        addr_off = address >> offset_eff;
        addr_tag = address >> (5'(offset_eff) + 5'(sets_eff));
        for (int i = 0; i < SET_W; i++)
        begin
            set_mask[i] = (i < int'(sets_eff));
        end
        set_idx = SET_W'(addr_off) & set_mask;
        tag_val = TAG_W'(addr_tag);
    end

    // Two-entry queue toward the back end.
    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_set    = set_q_reg[rptr_reg];
    assign q_tag    = tag_q_reg[rptr_reg];
    assign q_wr     = wr_q_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            set_q_reg[wptr_reg] <= set_idx;
            tag_q_reg[wptr_reg] <= tag_val;
            wr_q_reg[wptr_reg]  <= operation;
        end
    end

endmodule

@@ hw/rtl/sact_back.sv @@
module sact_back #(
    parameter int NUM_SETS = sact_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = sact_pkg::NUM_WAYS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sact_pkg::POLICY_W-1:0]     policy,
    input  logic [sact_pkg::WAYS_LOG_W-1:0]   ways_eff,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] q_set,
    input  logic [sact_pkg::TAG_W-1:0]        q_tag,
    input  logic                              q_wr,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic [sact_pkg::WAY_OUT_W-1:0]    way_used,
    output logic                              victim_valid,
    output logic                              victim_dirty,
    output logic [sact_pkg::TAG_W-1:0]        victim_tag
);
    import sact_pkg::*;

    localparam int SET_W   = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W   = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
    localparam int WL_MAX  = $clog2(NUM_WAYS + 1) - 1;
    localparam int PLRU_W  = NUM_WAYS > 1 ? NUM_WAYS - 1 : 1;
    localparam int PIDX_W  = PLRU_W > 1 ? $clog2(PLRU_W) : 1;
    localparam int NODE_W  = WAY_W + 1;
    localparam int TAGS_LO = 2 * NUM_WAYS + NUM_WAYS * WAY_W + PLRU_W;
    localparam int ROW_W   = TAGS_LO + NUM_WAYS * TAG_W;

    back_state_t       state_reg, state_next;
    logic [NUM_SETS-1:0] row_init_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              wr_reg;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic              out_valid_reg;
    logic              hit_reg;
    logic [WAY_OUT_W-1:0] way_reg;
    logic              vvalid_reg, vdirty_reg;
    logic [TAG_W-1:0]  vtag_reg;

    logic              issue, fire, row_ok;
    logic [ROW_W-1:0]  rdata, wdata;

    logic [NUM_WAYS-1:0] valid_c, dirty_c, in_use, valid_n, dirty_n;
    logic [WAY_W-1:0]  rank_c [NUM_WAYS];
    logic [WAY_W-1:0]  rank_n [NUM_WAYS];
    logic [TAG_W-1:0]  tag_c  [NUM_WAYS];
    logic [TAG_W-1:0]  tag_n  [NUM_WAYS];
    logic [PLRU_W-1:0] plru_c, plru_n;
    logic [WAY_W-1:0]  nmask, way, hit_way, empty_way, lru_way, plru_way, rnd_way;
    logic [WAY_W-1:0]  best, r_used;
    logic [NODE_W-1:0] node, tnode, nways;
    logic              found, empty, use_rnd;

    // Set row store: valid, dirty, ranks, tree and tags of all ways.
    sact_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
        .clk   (clk),
        .we    (fire),
        .waddr (set_reg),
        .wdata (wdata),
        .re    (issue),
        .raddr (q_set),
        .rdata (rdata)
    );

    assign q_ready = (state_reg == ST_IDLE);
    assign issue   = q_valid && q_ready;
    assign fire    = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign row_ok  = row_init_reg[set_reg];

    // Unpack the row; a set never written reads as its reset contents.
    always_comb
    begin
        nways = NODE_W'(1) << ways_eff;
        nmask = WAY_W'(nways - NODE_W'(1));
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            in_use[k]  = ((WAY_W'(k) & ~nmask) == '0);
            valid_c[k] = row_ok && rdata[k];
            dirty_c[k] = row_ok && rdata[NUM_WAYS + k];
            rank_c[k]  = row_ok ? rdata[2 * NUM_WAYS + k * WAY_W +: WAY_W] : WAY_W'(k);
            tag_c[k]   = rdata[TAGS_LO + k * TAG_W +: TAG_W];
        end
        plru_c = row_ok ? rdata[2 * NUM_WAYS + NUM_WAYS * WAY_W +: PLRU_W] : '0;
    end

    // Lookup, fill choice and victim choice.
    always_comb
    begin
        found     = 1'b0;
        hit_way   = '0;
        empty     = 1'b0;
        empty_way = '0;
        best      = '0;
        lru_way   = '0;
        for (int k = NUM_WAYS - 1; k >= 0; k--)
        begin
            if (in_use[k] && valid_c[k] && tag_c[k] == tag_reg)
            begin
                found   = 1'b1;
                hit_way = WAY_W'(k);
            end
            if (in_use[k] && !valid_c[k])
            begin
                empty     = 1'b1;
                empty_way = WAY_W'(k);
            end
        end
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            if (in_use[k] && rank_c[k] >= best)
            begin
                best    = rank_c[k];
                lru_way = WAY_W'(k);
            end
        end
        node = NODE_W'(1);
        for (int i = 0; i < WL_MAX; i++)
        begin
            if (i < int'(ways_eff))
            begin
                node = {node[NODE_W-2:0], plru_c[PIDX_W'(node - NODE_W'(1))]};
            end
        end
        plru_way  = WAY_W'(node) & nmask;
        lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        rnd_way   = WAY_W'(lfsr_next) & nmask;
        use_rnd   = !found && !empty && (policy == POL_RANDOM);

        priority if (found)
        begin
            way = hit_way;
        end
        else if (empty)
        begin
            way = empty_way;
        end
        else if (policy == POL_RANDOM)
        begin
            way = rnd_way;
        end
        else if (policy == POL_PLRU)
        begin
            way = plru_way;
        end
        else
        begin
            way = lru_way;
        end
    end

    // New row: line update, rank move to front, tree pointed away from the used way.
    always_comb
    begin
        valid_n = valid_c;
        dirty_n = dirty_c;
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            tag_n[k] = tag_c[k];
        end
        if (found)
        begin
            dirty_n[way] = dirty_c[way] | wr_reg;
        end
        else
        begin
            valid_n[way] = 1'b1;
            dirty_n[way] = wr_reg;
            tag_n[way]   = tag_reg;
        end
        r_used = rank_c[way];
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            rank_n[k] = (rank_c[k] < r_used) ? rank_c[k] + WAY_W'(1) : rank_c[k];
        end
        rank_n[way] = '0;
        plru_n = plru_c;
        tnode  = nways + NODE_W'(way);
        for (int i = 0; i < WL_MAX; i++)
        begin
            if (i < int'(ways_eff))
            begin
                plru_n[PIDX_W'((tnode >> 1) - NODE_W'(1))] = ~tnode[0];
                tnode = tnode >> 1;
            end
        end
        wdata = '0;
        wdata[NUM_WAYS-1:0]            = valid_n;
        wdata[NUM_WAYS +: NUM_WAYS]    = dirty_n;
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            wdata[2 * NUM_WAYS + k * WAY_W +: WAY_W] = rank_n[k];
            wdata[TAGS_LO + k * TAG_W +: TAG_W]      = tag_n[k];
        end
        wdata[2 * NUM_WAYS + NUM_WAYS * WAY_W +: PLRU_W] = plru_n;
    end

    // Sequencer: read the set, then resolve and write it back.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (issue)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_init_reg  <= '0;
            lfsr_reg      <= LFSR_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                row_init_reg[set_reg] <= 1'b1;
                out_valid_reg         <= 1'b1;
                if (use_rnd)
                begin
                    lfsr_reg <= lfsr_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            set_reg <= q_set;
            tag_reg <= q_tag;
            wr_reg  <= q_wr;
        end
        if (fire)
        begin
            hit_reg    <= found;
            way_reg    <= WAY_OUT_W'(way);
            vvalid_reg <= !found && !empty;
            vdirty_reg <= !found && !empty && dirty_c[way];
            vtag_reg   <= (!found && !empty) ? tag_c[way] : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign way_used     = way_reg;
    assign victim_valid = vvalid_reg;
    assign victim_dirty = vdirty_reg;
    assign victim_tag   = vtag_reg;

endmodule

@@ hw/rtl/set_assoc_cache_tag_replacement_top.sv @@
// Path: an input transfer waits in the two-entry front queue; the back end then reads the
// set row and, once its result register is free, resolves the access and writes the row back.
// A new access is taken only after the previous one has been written back in the row memory.
// Reset: asynchronous, active low; all lines invalid and clean, LRU ranks equal way
// index, tree bits zero, LFSR seeded; per-set init bits make a set read as reset
// contents until first written, so no clearing pass is needed.
module set_assoc_cache_tag_replacement_top #(
    parameter int NUM_SETS  = sact_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS  = sact_pkg::NUM_WAYS_DEF,
    parameter int ADDR_BITS = sact_pkg::ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sact_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sact_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ADDR_BITS-1:0]              address,
    input  logic                              operation,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic [sact_pkg::WAY_OUT_W-1:0]    way_used,
    output logic                              victim_valid,
    output logic                              victim_dirty,
    output logic [sact_pkg::TAG_W-1:0]        victim_tag
);
    import sact_pkg::*;

    localparam int SET_W  = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int WL_MAX = $clog2(NUM_WAYS + 1) - 1;
    localparam int SL_MAX = $clog2(NUM_SETS + 1) - 1;

    logic [POLICY_W-1:0]   policy_reg;
    logic [WAYS_LOG_W-1:0] ways_reg, ways_eff;
    logic [SETS_LOG_W-1:0] sets_reg, sets_eff;
    logic [OFFSET_W-1:0]   offset_reg, offset_eff;
    logic                  q_valid, q_ready, q_wr;
    logic [SET_W-1:0]      q_set;
    logic [TAG_W-1:0]      q_tag;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_RST;
            ways_reg   <= WAYS_LOG_RST;
            sets_reg   <= SETS_LOG_RST;
            offset_reg <= OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY:    policy_reg <= POLICY_W'(cfg_data);
                CFG_WAYS_LOG2: ways_reg   <= WAYS_LOG_W'(cfg_data);
                CFG_SETS_LOG2: sets_reg   <= SETS_LOG_W'(cfg_data);
                CFG_OFFSET:    offset_reg <= cfg_data;
                default:       policy_reg <= policy_reg;
            endcase
        end
    end

    // Sizes beyond the built store are lowered to fit; the offset is capped at OFFSET_MAX.
    always_comb
    begin
        ways_eff   = (int'(ways_reg) > WL_MAX) ? WAYS_LOG_W'(WL_MAX) : ways_reg;
        sets_eff   = (int'(sets_reg) > SL_MAX) ? SETS_LOG_W'(SL_MAX) : sets_reg;
        offset_eff = (int'(offset_reg) > OFFSET_MAX) ? OFFSET_W'(OFFSET_MAX) : offset_reg;
    end

    sact_front #(.NUM_SETS(NUM_SETS), .ADDR_BITS(ADDR_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sets_eff   (sets_eff),
        .offset_eff (offset_eff),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .address    (address),
        .operation  (operation),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_set      (q_set),
        .q_tag      (q_tag),
        .q_wr       (q_wr)
    );

    sact_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .policy       (policy_reg),
        .ways_eff     (ways_eff),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_set        (q_set),
        .q_tag        (q_tag),
        .q_wr         (q_wr),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .way_used     (way_used),
        .victim_valid (victim_valid),
        .victim_dirty (victim_dirty),
        .victim_tag   (victim_tag)
    );

endmodule

@@ hw/rtl/sact_chk.sv @@
module sact_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            hit,
    input logic [sact_pkg::WAY_OUT_W-1:0]  way_used,
    input logic                            victim_valid,
    input logic                            victim_dirty,
    input logic [sact_pkg::TAG_W-1:0]      victim_tag
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(way_used) && $stable(victim_tag))
        else $error("result changed while stalled");

    // A hit evicts nothing.
    a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !victim_valid && !victim_dirty && victim_tag == '0)
        else $error("hit reports a victim");

    // Without an eviction the victim fields are clear.
    a_no_victim_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !victim_valid |-> !victim_dirty && victim_tag == '0)
        else $error("victim fields set without eviction");

endmodule

bind set_assoc_cache_tag_replacement_top sact_chk u_sact_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .way_used     (way_used),
    .victim_valid (victim_valid),
    .victim_dirty (victim_dirty),
    .victim_tag   (victim_tag)
);
